### rtl/emahmg_pkg.sv
// Package for the moving-average hysteresis mode governor.
// Holds widths, register indexes, the mode type and the shared structs.
// No dependencies.
package emahmg_pkg;

  localparam int AVG_FRAC_BITS = 16;
  localparam int ALPHA_BITS    = 16;
  localparam int AVG_W         = 48;
  localparam int CNT_W         = 32;
  localparam int LIMIT_W       = 31;
  localparam int RUN_W         = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 56;

  localparam logic signed [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic signed [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};
  localparam logic [RUN_W-1:0]        RUN_MAX = '1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_DEG1   = 2'd1,
    MODE_DEG2   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_LIMIT = 8'd0,
    REG_DEG1_LIMIT   = 8'd1,
    REG_STOP_LIMIT   = 8'd2,
    REG_ALPHA        = 8'd3,
    REG_EXPECTED     = 8'd4,
    REG_REC_NORMAL   = 8'd5,
    REG_REC_DEG1     = 8'd6,
    REG_INIT_MODE    = 8'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]    normal_limit;
    logic [LIMIT_W-1:0]    deg1_limit;
    logic [LIMIT_W-1:0]    stop_limit;
    logic [ALPHA_BITS-1:0] alpha;
    logic [15:0]           expected;
    logic [RUN_W-1:0]      rec_normal;
    logic [RUN_W-1:0]      rec_deg1;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } preset_t;

  typedef struct packed {
    logic [CNT_W-1:0]        prev;
    logic signed [AVG_W-1:0] avg;
    mode_t                   mode;
    logic [RUN_W-1:0]        run;
    logic                    stopped;
  } gov_state_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg;
    logic                    stop;
    logic                    changed;
    mode_t                   mode;
  } result_t;

endpackage

### rtl/emahmg_cfg.sv
// Configuration register file of the mode governor.
// Decodes index writes into cfg_t and issues the mode preset strobe.
// Depends on emahmg_pkg.
module emahmg_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [emahmg_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [emahmg_pkg::CFG_DATA_W-1:0] wr_data,
  output emahmg_pkg::cfg_t                  cfg,
  output emahmg_pkg::preset_t               preset
);
  import emahmg_pkg::*;

  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  preset_t preset_nxt;

  always_comb begin
    cfg_nxt    = cfg_r;
    preset_nxt = '{valid: 1'b0, mode: MODE_NORMAL};
    if (wr_en) begin
      unique case (wr_index)
        REG_NORMAL_LIMIT: cfg_nxt.normal_limit = wr_data[LIMIT_W-1:0];
        REG_DEG1_LIMIT:   cfg_nxt.deg1_limit   = wr_data[LIMIT_W-1:0];
        REG_STOP_LIMIT:   cfg_nxt.stop_limit   = wr_data[LIMIT_W-1:0];
        REG_ALPHA:        cfg_nxt.alpha        = wr_data[ALPHA_BITS-1:0];
        REG_EXPECTED:     cfg_nxt.expected     = wr_data[15:0];
        REG_REC_NORMAL:   cfg_nxt.rec_normal   = wr_data[RUN_W-1:0];
        REG_REC_DEG1:     cfg_nxt.rec_deg1     = wr_data[RUN_W-1:0];
        REG_INIT_MODE: begin
          preset_nxt.valid = 1'b1;
          preset_nxt.mode  = (wr_data[1:0] == 2'd3) ? MODE_DEG2 : mode_t'(wr_data[1:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_limit <= LIMIT_W'(5);
      cfg_r.deg1_limit   <= LIMIT_W'(10);
      cfg_r.stop_limit   <= LIMIT_W'(20);
      cfg_r.alpha        <= ALPHA_BITS'(6554);
      cfg_r.expected     <= 16'd10;
      cfg_r.rec_normal   <= RUN_W'(5);
      cfg_r.rec_deg1     <= RUN_W'(15);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg    = cfg_r;
  assign preset = preset_nxt;

endmodule

### rtl/emahmg_core.sv
// Single-pass update of the governor for one tick: shortfall, average,
// saturation, limit compares and mode hysteresis. Depends on emahmg_pkg.
module emahmg_core (
  input  logic [emahmg_pkg::CNT_W-1:0] count_value,
  input  emahmg_pkg::gov_state_t       st,
  input  emahmg_pkg::cfg_t             cfg,
  output emahmg_pkg::gov_state_t       st_nxt,
  output emahmg_pkg::result_t          res
);
  import emahmg_pkg::*;

  localparam int TW = CNT_W + AVG_FRAC_BITS;
  localparam int DW = ((TW > AVG_W) ? TW : AVG_W) + 1;
  localparam int PW = DW + ALPHA_BITS + 1;
  localparam int SW = DW + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(AVG_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(AVG_MIN);

  logic [CNT_W-1:0]        raw;
  logic signed [TW-1:0]    target;
  logic signed [DW-1:0]    diff;
  logic signed [PW-1:0]    prod;
  logic signed [SW-1:0]    step;
  logic signed [SW-1:0]    na_w;
  logic signed [AVG_W-1:0] na;
  logic signed [SW-1:0]    na_x;
  logic signed [SW-1:0]    lim_n;
  logic signed [SW-1:0]    lim_d1;
  logic signed [SW-1:0]    lim_s;
  logic                    above_n;
  logic                    above_d1;
  logic                    above_s;
  logic [RUN_W-1:0]        run_inc;
  gov_state_t              nxt;

  always_comb begin
    raw    = st.prev + CNT_W'(cfg.expected) - count_value;
    target = $signed({raw, {AVG_FRAC_BITS{1'b0}}});
    diff   = DW'(target) - DW'(st.avg);
    prod   = PW'(diff) * PW'($signed({1'b0, cfg.alpha}));
    step   = SW'(prod >>> ALPHA_BITS);
    na_w   = SW'(st.avg) + step;
    if (na_w > SAT_HI) begin
      na = AVG_MAX;
    end else if (na_w < SAT_LO) begin
      na = AVG_MIN;
    end else begin
      na = AVG_W'(na_w);
    end
    na_x     = SW'(na);
    lim_n    = $signed(SW'({cfg.normal_limit, {AVG_FRAC_BITS{1'b0}}}));
    lim_d1   = $signed(SW'({cfg.deg1_limit, {AVG_FRAC_BITS{1'b0}}}));
    lim_s    = $signed(SW'({cfg.stop_limit, {AVG_FRAC_BITS{1'b0}}}));
    above_n  = na_x > lim_n;
    above_d1 = na_x > lim_d1;
    above_s  = na_x > lim_s;
    run_inc  = (st.run == RUN_MAX) ? st.run : st.run + RUN_W'(1);
  end

  always_comb begin
    nxt = st;
    if (!st.stopped) begin
      nxt.avg = na;
      if (above_s) begin
        nxt.stopped = 1'b1;
      end else begin
        nxt.prev = count_value;
        unique case (st.mode)
          MODE_NORMAL: begin
            if (above_n) begin
              nxt.mode = MODE_DEG1;
              nxt.run  = '0;
            end
          end
          MODE_DEG1: begin
            if (above_d1) begin
              nxt.mode = MODE_DEG2;
              nxt.run  = '0;
            end else if (!above_n) begin
              if (run_inc >= cfg.rec_normal) begin
                nxt.mode = MODE_NORMAL;
                nxt.run  = '0;
              end else begin
                nxt.run = run_inc;
              end
            end else begin
              nxt.run = '0;
            end
          end
          MODE_DEG2: begin
            if (!above_d1) begin
              if (run_inc >= cfg.rec_deg1) begin
                nxt.mode = MODE_DEG1;
                nxt.run  = '0;
              end else begin
                nxt.run = run_inc;
              end
            end else begin
              nxt.run = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign st_nxt      = nxt;
  assign res.avg     = nxt.avg;
  assign res.stop    = nxt.stopped;
  assign res.changed = (nxt.mode != st.mode);
  assign res.mode    = nxt.mode;

endmodule

### rtl/ema_hysteresis_mode_governor.sv
// Top level of the moving-average hysteresis mode governor.
// Input register, governor state, result register; uses emahmg_cfg,
// emahmg_core and emahmg_pkg.
//
//   channel   ports                                   payload
//   input     in_tvalid  in_tready  in_tdata[31:0]    count_value
//   result    out_tvalid out_tready out_tdata[55:0]   mode, mode_changed, stop, average
//   config    cfg_valid  cfg_ready  cfg_index cfg_data register writes
//
// One item per cycle while the result side is not stalled; an accepted input passes through
// the input register and then the result register. The rate is set by the state loop:
// shortfall, one 49x17 multiply, add, saturate and compares close through the state register.
// Reset restores the register defaults and clears the governor state and valid flags; no clearing pass.
// A stalled result holds its register while the input register still takes
// one more item.
module ema_hysteresis_mode_governor (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [emahmg_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] count_value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [emahmg_pkg::OUT_TDATA_W-1:0] out_tdata,  // [1:0] mode, [2] mode_changed,
                                                         // [3] stop, [51:4] average, pad
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [emahmg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [emahmg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import emahmg_pkg::*;

  cfg_t             cfg;
  preset_t          preset;
  logic             in_vld_r;
  logic [CNT_W-1:0] in_cnt_r;
  logic             out_vld_r;
  result_t          out_data_r;
  gov_state_t       state_r;
  gov_state_t       state_nxt;
  result_t          res;
  logic             ld;

  assign cfg_ready = 1'b1;

  emahmg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .preset   (preset)
  );

  emahmg_core u_core (
    .count_value (in_cnt_r),
    .st          (state_r),
    .cfg         (cfg),
    .st_nxt      (state_nxt),
    .res         (res)
  );

  assign ld        = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cnt_r <= in_tdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{prev: '0, avg: '0, mode: MODE_NORMAL, run: '0, stopped: 1'b0};
    end else if (ld) begin
      state_r <= state_nxt;
    end else if (preset.valid && !state_r.stopped) begin
      state_r.mode <= preset.mode;
      state_r.run  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, out_data_r.avg, out_data_r.stop, out_data_r.changed,
                       out_data_r.mode};

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stopped |=> state_r.stopped)
    else $error("stop flag cleared after latching");

  a_run_not_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.run != '0) |-> (state_r.mode != MODE_NORMAL))
    else $error("recovery run counting in normal mode");

  a_frozen_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && state_r.stopped) |=> !out_data_r.changed)
    else $error("mode change reported while stopped");
`endif

endmodule

### sim/ema_hysteresis_mode_governor_tb.sv
// Self-checking testbench for ema_hysteresis_mode_governor: tick items with
// bursty sender and stalling receiver, checked against an in-bench governor model.
// Depends on emahmg_pkg and the governor RTL only.
module ema_hysteresis_mode_governor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import emahmg_pkg::*;

  localparam longint AVG_CEIL  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AVG_FLOOR = -AVG_CEIL - 1;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;
  localparam logic [1:0] MODE_CODE_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_ITEMS = 1413;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_ONE_IN_FOUR, READY_LONG_HOLD} ready_style_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // governor copy: settings
  logic [LIMIT_W-1:0]    lim_normal, lim_deg1, lim_stop;
  logic [ALPHA_BITS-1:0] alpha;
  logic [15:0]           expected;
  logic [RUN_W-1:0]      rec_normal, rec_deg1;
  mode_t                 init_mode;
  // governor copy: state
  logic [CNT_W-1:0]      st_prev;
  longint                st_avg;
  mode_t                 st_mode;
  logic [RUN_W-1:0]      st_run;
  bit                    st_stopped;

  result_t      expected_results[$];
  int           mismatch_count = 0;
  int           burst_left = 0;
  ready_style_t ready_style = READY_ALWAYS;
  int           style_left = 0;
  int           ready_phase = 0;

  ema_hysteresis_mode_governor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("ema_hysteresis_mode_governor test failed");
    $finish;
  end

  function automatic void reset_governor();
    lim_normal = 5;
    lim_deg1   = 10;
    lim_stop   = 20;
    alpha      = 6554;
    expected   = 10;
    rec_normal = 5;
    rec_deg1   = 15;
    init_mode  = MODE_NORMAL;
    st_prev    = '0;
    st_avg     = 0;
    st_mode    = MODE_NORMAL;
    st_run     = '0;
    st_stopped = 1'b0;
  endfunction

  function automatic longint scaled(logic [LIMIT_W-1:0] lim);
    return longint'(lim) <<< AVG_FRAC_BITS;
  endfunction

  function automatic void recovery_step(logic [RUN_W-1:0] need, mode_t target);
    if (st_run != RUN_MAX) st_run++;
    if (st_run >= need) begin
      st_mode = target;
      st_run  = '0;
    end
  endfunction

  function automatic result_t governor_tick(logic [CNT_W-1:0] count);
    logic [CNT_W-1:0]    raw;
    longint              delta, diff, na;
    logic signed [127:0] wide;
    mode_t               old_mode;
    result_t             r;
    old_mode = st_mode;
    if (!st_stopped) begin
      raw   = st_prev + CNT_W'(expected) - count;
      delta = longint'($signed(raw));
      diff  = (delta <<< AVG_FRAC_BITS) - st_avg;
      wide  = diff;
      wide  = wide * $signed({1'b0, alpha});
      wide  = wide >>> ALPHA_BITS;
      na    = st_avg + longint'(wide[63:0]);
      if (na > AVG_CEIL) na = AVG_CEIL;
      if (na < AVG_FLOOR) na = AVG_FLOOR;
      st_avg = na;
      if (na > scaled(lim_stop)) begin
        st_stopped = 1'b1;
      end else begin
        case (st_mode)
          MODE_NORMAL: begin
            if (na > scaled(lim_normal)) begin
              st_mode = MODE_DEG1;
              st_run  = '0;
            end
          end
          MODE_DEG1: begin
            if (na > scaled(lim_deg1)) begin
              st_mode = MODE_DEG2;
              st_run  = '0;
            end else if (na <= scaled(lim_normal)) begin
              recovery_step(rec_normal, MODE_NORMAL);
            end else begin
              st_run = '0;
            end
          end
          default: begin
            if (na <= scaled(lim_deg1)) recovery_step(rec_deg1, MODE_DEG1);
            else st_run = '0;
          end
        endcase
        st_prev = count;
      end
    end
    r.mode    = st_mode;
    r.changed = (st_mode != old_mode);
    r.stop    = st_stopped;
    r.avg     = st_avg[AVG_W-1:0];
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] next_count(int shortfall);
    return st_prev + CNT_W'(expected) - shortfall;
  endfunction

  function automatic logic [RUN_W-1:0] pick_run();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RUN_MAX;
      default: return RUN_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(logic [OUT_TDATA_W-1:0] word);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing outstanding", word, 0);
      return;
    end
    want = expected_results.pop_front();
    if (word[1:0] != want.mode) report_mismatch("mode", word[1:0], want.mode);
    if (word[2] != want.changed) report_mismatch("mode_changed", word[2], want.changed);
    if (word[3] != want.stop) report_mismatch("stop", word[3], want.stop);
    if (word[51:4] != want.avg) report_mismatch("average", word[51:4], want.avg);
    if (word[OUT_TDATA_W-1:52] != '0) report_mismatch("pad", word[OUT_TDATA_W-1:52], 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    if (style_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(32, 200);
    end
    style_left--;
    ready_phase++;
    case (ready_style)
      READY_ALWAYS:      out_tready <= 1'b1;
      READY_COIN:        out_tready <= ($urandom_range(0, 1) == 1);
      READY_ONE_IN_FOUR: out_tready <= (ready_phase % 4 == 0);
      default:           out_tready <= (ready_phase % 16 >= 10);
    endcase
  end

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic send_count(logic [CNT_W-1:0] count);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= count;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(governor_tick(count));
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NORMAL_LIMIT: lim_normal = data[LIMIT_W-1:0];
      REG_DEG1_LIMIT:   lim_deg1   = data[LIMIT_W-1:0];
      REG_STOP_LIMIT:   lim_stop   = data[LIMIT_W-1:0];
      REG_ALPHA:        alpha      = data[ALPHA_BITS-1:0];
      REG_EXPECTED:     expected   = data[15:0];
      REG_REC_NORMAL:   rec_normal = data[RUN_W-1:0];
      REG_REC_DEG1:     rec_deg1   = data[RUN_W-1:0];
      REG_INIT_MODE: begin
        if (data[1:0] == MODE_CODE_UNUSED) init_mode = MODE_DEG2;
        else init_mode = mode_t'(data[1:0]);
        if (!st_stopped) begin
          st_mode = init_mode;
          st_run  = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic test_default_settings();
    int k;
    for (k = 0; k < 2; k++) send_count(next_count(0));
    for (k = 0; k < 6; k++) send_count(next_count(18));
    for (k = 0; k < 7; k++) send_count(next_count(-10));
  endtask

  task automatic test_field_extremes();
    set_reg(REG_STOP_LIMIT, LIMIT_TOP);
    set_reg(REG_NORMAL_LIMIT, 0);
    set_reg(REG_DEG1_LIMIT, LIMIT_TOP);
    set_reg(REG_ALPHA, 32'h0000_FFFF);
    set_reg(REG_EXPECTED, 32'h0000_FFFF);
    send_count(32'h0000_0000);
    send_count(32'hFFFF_FFFF);
    send_count(next_count(32'sh7FFF_FFFF));
    send_count(next_count(-32'sh8000_0000));
    set_reg(REG_ALPHA, 0);
    set_reg(REG_EXPECTED, 0);
    set_reg(REG_NORMAL_LIMIT, LIMIT_TOP);
    set_reg(REG_DEG1_LIMIT, 0);
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFF);
  endtask

  task automatic test_register_presets();
    int k;
    set_reg(REG_NORMAL_LIMIT, 5);
    set_reg(REG_DEG1_LIMIT, 10);
    set_reg(REG_ALPHA, 32'h0000_FFFF);
    set_reg(REG_EXPECTED, 10);
    for (k = 0; k < 4; k++) send_count(next_count(0));
    // zero recovery length recovers after one quiet tick
    set_reg(REG_REC_NORMAL, 0);
    set_reg(REG_INIT_MODE, MODE_DEG1);
    send_count(next_count(0));
    // out-of-range preset lands in degraded two
    set_reg(REG_REC_DEG1, 1);
    set_reg(REG_INIT_MODE, MODE_CODE_UNUSED);
    send_count(next_count(0));
    set_reg(CFG_IDX_W'($urandom_range(8, 255)), $urandom);
    send_count(next_count(0));
    set_reg(REG_INIT_MODE, MODE_NORMAL);
  endtask

  task automatic test_random_traffic();
    int                    sent, seg_len, k, phase_left, bias, bias_top, spread;
    logic [LIMIT_W-1:0]    nl, dl, sl;
    logic [ALPHA_BITS-1:0] a;
    logic [RUN_W-1:0]      rn, rd;
    logic [31:0]           junk;
    longint                stop_floor;
    bit                    noisy, rewrite, long_run;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      rewrite = ($urandom_range(0, 3) != 0);
      noisy   = rewrite && ($urandom_range(0, 3) == 0);
      rn = pick_run();
      rd = pick_run();
      if (rewrite) begin
        junk = $urandom;
        nl = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom) : LIMIT_W'($urandom_range(0, 30));
        dl = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom) : nl + LIMIT_W'($urandom_range(0, 30));
        a  = ($urandom_range(0, 7) == 0) ? ALPHA_BITS'($urandom) :
                                           ALPHA_BITS'($urandom_range(3000, 40000));
        // hold the stop limit clear of the current average and the planned shortfall
        stop_floor = ((st_avg > 0) ? (st_avg >>> AVG_FRAC_BITS) : 0) + 4000;
        if (noisy || stop_floor + 1000 > longint'(LIMIT_TOP)) sl = LIMIT_TOP;
        else if ($urandom_range(0, 1) == 0) sl = LIMIT_W'(stop_floor + $urandom_range(0, 1000));
        else sl = LIMIT_W'($urandom_range(32'(LIMIT_TOP), 32'(stop_floor)));
        set_reg(REG_NORMAL_LIMIT, {junk[31], nl});
        set_reg(REG_DEG1_LIMIT, {junk[30], dl});
        set_reg(REG_STOP_LIMIT, {junk[29], sl});
        set_reg(REG_ALPHA, {junk[31:16], a});
        set_reg(REG_EXPECTED, {junk[15:0], 16'($urandom)});
        set_reg(REG_REC_NORMAL, {junk[31:8], rn});
        set_reg(REG_REC_DEG1, {junk[23:0], rd});
        if ($urandom_range(0, 2) == 0) set_reg(REG_INIT_MODE, {junk[31:2], 2'($urandom)});
        if ($urandom_range(0, 7) == 0) set_reg(CFG_IDX_W'($urandom_range(8, 255)), $urandom);
      end
      long_run = (rec_normal > 100 || rec_deg1 > 100);
      bias_top = 2 * ((lim_deg1 > 1000) ? 1000 : int'(lim_deg1)) + 40;
      seg_len  = long_run ? 300 : $urandom_range(20, 100);
      if (seg_len > RANDOM_ITEMS - sent) seg_len = RANDOM_ITEMS - sent;
      spread   = $urandom_range(0, 20);
      phase_left = 0;
      bias = 0;
      for (k = 0; k < seg_len; k++) begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(4, long_run ? 280 : 40);
          bias = $urandom_range(0, bias_top) - 20;
        end
        phase_left--;
        if (noisy && $urandom_range(0, 9) == 0) send_count($urandom);
        else send_count(next_count(bias + $urandom_range(0, 2 * spread) - spread));
      end
      sent += seg_len;
    end
  endtask

  task automatic test_stop_latch();
    int k;
    set_reg(REG_STOP_LIMIT, LIMIT_TOP);
    set_reg(REG_ALPHA, 32'h0000_FFFF);
    for (k = 0; k < 3; k++) send_count(next_count(0));
    set_reg(REG_NORMAL_LIMIT, 5);
    set_reg(REG_DEG1_LIMIT, 10);
    set_reg(REG_ALPHA, 32'h0000_8000);
    set_reg(REG_INIT_MODE, MODE_NORMAL);
    set_reg(REG_STOP_LIMIT, 0);
    // stop tick: the average moves, the mode holds
    send_count(next_count(1000));
    for (k = 0; k < 3; k++) send_count($urandom);
    set_reg(REG_INIT_MODE, MODE_DEG2);
    for (k = 0; k < 2; k++) send_count($urandom);
  endtask

  initial begin
    reset_governor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_settings();
    test_field_extremes();
    test_register_presets();
    test_random_traffic();
    test_stop_latch();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ema_hysteresis_mode_governor test passed");
    end else begin
      $display("ema_hysteresis_mode_governor test failed");
    end
    $finish;
  end

endmodule
